### src/slrp_pkg.sv
`default_nettype none

package slrp_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned IP_W = 32;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned REC_W = IP_W + PORT_W;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned OUT_TUSER_W = 3;
  localparam int unsigned NAME_CNT = 3;
  localparam int unsigned NAME_MAX_W = 8 * 18;

  localparam logic [DATA_W-1:0] BYTE_FF = 8'hFF;
  localparam logic [DATA_W-1:0] BYTE_BSLASH = 8'h5C;
  localparam logic [DATA_W-1:0] BYTE_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] BYTE_NEWLINE = 8'h0A;
  localparam logic [REC_W-1:0] REC_EOT = 48'h0000_0045_4F54;

  localparam logic [2:0] HDR_DONE_COUNT = 3'd4;
  localparam logic [2:0] REC_FULL_COUNT = 3'd6;
  localparam logic [2:0] REC_EOT_COUNT = 3'd3;
  localparam logic [4:0] NAME_POS_MAX = 5'd31;

  // Known response names, right aligned, first character in the high byte.
  localparam int unsigned NAME_LIST = 0;
  localparam int unsigned NAME_STATUS = 1;
  localparam int unsigned NAME_INFO = 2;
  localparam logic [NAME_MAX_W-1:0] NAME_STR [NAME_CNT] = '{
    NAME_MAX_W'("getserversResponse"),
    NAME_MAX_W'("statusResponse"),
    NAME_MAX_W'("infoResponse")
  };
  localparam logic [4:0] NAME_LEN [NAME_CNT] = '{5'd18, 5'd14, 5'd12};

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_SKIP,
    PH_RECORD,
    PH_DONE
  } phase_t;

  typedef enum logic [CODE_W-1:0] {
    ST_EOT,
    ST_AFTER_RECORD,
    ST_NO_BACKSLASH,
    ST_SHORT_RECORD,
    ST_BAD_SEP,
    ST_UNKNOWN_NAME,
    ST_UNDECODED
  } status_t;

  typedef struct packed {
    logic [NAME_CNT-1:0] flags;
    logic [4:0] pos;
    logic delim;
    logic hit_list;
    logic hit_other;
  } nm_res_t;

  typedef struct packed {
    logic record_valid;
    logic [IP_W-1:0] server_ip;
    logic [PORT_W-1:0] server_port;
    logic status_valid;
    logic [CODE_W-1:0] status_code;
    logic header_ok;
  } result_t;

  // Character of a known name at a position; caller checks pos < len.
  function automatic logic [DATA_W-1:0] name_char(input logic [NAME_MAX_W-1:0] str,
                                                  input logic [4:0] len,
                                                  input logic [4:0] pos);
    logic [4:0] idx;
    logic [NAME_MAX_W-1:0] sh;
    idx = (pos < len) ? (len - 5'd1 - pos) : 5'd0;
    sh = str >> {idx, 3'b000};
    return sh[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/slrp_name_match.sv
`default_nettype none

module slrp_name_match import slrp_pkg::*; (
  input  wire logic [DATA_W-1:0]   data_byte,
  input  wire logic [NAME_CNT-1:0] flags_in,
  input  wire logic [4:0]          pos_in,
  output nm_res_t                  res
);

  logic                delim;
  logic [NAME_CNT-1:0] miss;

  assign delim = (data_byte == BYTE_BSLASH) || (data_byte == BYTE_SPACE) ||
                 (data_byte == BYTE_NEWLINE);

  always_comb begin
    for (int k = 0; k < NAME_CNT; k++) begin
      miss[k] = (pos_in >= NAME_LEN[k]) ||
                (name_char(NAME_STR[k], NAME_LEN[k], pos_in) != data_byte);
    end
  end

  always_comb begin
    res.delim = delim;
    if (delim) begin
      res.flags = flags_in;
      res.pos = pos_in;
    end else begin
      res.flags = flags_in & ~miss;
      res.pos = (pos_in < NAME_POS_MAX) ? pos_in + 5'd1 : pos_in;
    end
    res.hit_list = res.flags[NAME_LIST] && (res.pos == NAME_LEN[NAME_LIST]);
    res.hit_other = (res.flags[NAME_STATUS] && (res.pos == NAME_LEN[NAME_STATUS])) ||
                    (res.flags[NAME_INFO] && (res.pos == NAME_LEN[NAME_INFO]));
  end

endmodule

`default_nettype wire

### src/slrp_out_reg.sv
`default_nettype none

module slrp_out_reg import slrp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load,
  input  wire result_t                res,
  output      logic                   free,
  input  wire logic                   out_tready,
  output      logic                   out_tvalid,
  output      logic [OUT_TDATA_W-1:0] out_tdata,
  output      logic [OUT_TUSER_W-1:0] out_tuser
);

  logic    valid_r;
  result_t res_r;

  // Take a new result when empty or when the held one leaves this cycle.
  assign free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata = {5'b0, res_r.status_code, res_r.server_port, res_r.server_ip};
  assign out_tuser = {res_r.header_ok, res_r.status_valid, res_r.record_valid};

endmodule

`default_nettype wire

### src/server_list_response_parser.sv
`default_nettype none

// Server-list response parser. Feed one datagram a byte per beat on the in_
// channel, with in_tlast on its final byte. An optional four-byte 0xFF header
// is stripped, the response name is matched against getserversResponse,
// statusResponse and infoResponse, and for a server list every six-byte record
// (four address bytes, big-endian port) is delivered as one out_ beat when its
// separator byte arrives. Each datagram also ends in exactly one status beat
// (possibly merged with the last record's beat); bytes after the status are
// dropped until in_tlast, and every in_tlast rearms the parser. Throughput is
// one byte per clock: the whole per-byte step is combinational compares and
// a 48-bit shift between the parser state registers and the output register,
// so in_tready drops only while a result sits in the output register and
// out_tready is low.
module server_list_response_parser import slrp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [DATA_W-1:0]      in_tdata,   // [7:0] data_byte
  input  wire logic                   in_tlast,   // last_byte
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] server_ip, [47:32] server_port,
                                                  // [50:48] status_code, [55:51] zero
  output      logic [OUT_TUSER_W-1:0] out_tuser   // [0] record_valid, [1] status_valid,
                                                  // [2] header_ok
);

  phase_t              phase_r, phase_nxt;
  logic [2:0]          hdr_cnt_r, hdr_cnt_nxt;
  logic                hdr_seen_r, hdr_seen_nxt;
  logic [4:0]          name_pos_r, name_pos_nxt;
  logic [NAME_CNT-1:0] name_flags_r, name_flags_nxt;
  logic [2:0]          rec_cnt_r, rec_cnt_nxt;
  logic [REC_W-1:0]    rec_bytes_r, rec_bytes_nxt;

  logic                accept;
  logic                out_free;
  logic                name_beat;
  logic [NAME_CNT-1:0] nm_flags_in;
  logic [4:0]          nm_pos_in;
  nm_res_t             nm;
  result_t             res;
  logic [2:0]          hdr_inc;
  logic [2:0]          rec_inc;
  logic [REC_W-1:0]    rec_shift;

  assign in_tready = out_free;
  assign accept = in_tvalid && in_tready;

  assign hdr_inc = hdr_cnt_r + 3'd1;
  assign rec_inc = rec_cnt_r + 3'd1;
  assign rec_shift = {rec_bytes_r[REC_W-DATA_W-1:0], in_tdata};

  // A broken header starts the name at the first byte; any 0xFF seen before
  // it counts as name bytes, which rules out every known name.
  always_comb begin
    if (phase_r == PH_HEADER) begin
      nm_flags_in = (hdr_cnt_r != 3'd0) ? '0 : '1;
      nm_pos_in = {2'b00, hdr_cnt_r};
    end else begin
      nm_flags_in = name_flags_r;
      nm_pos_in = name_pos_r;
    end
  end

  slrp_name_match u_name (
    .data_byte (in_tdata),
    .flags_in  (nm_flags_in),
    .pos_in    (nm_pos_in),
    .res       (nm)
  );

  // Per-byte step: next parser state and the beat's result.
  always_comb begin
    phase_nxt = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    hdr_seen_nxt = hdr_seen_r;
    name_pos_nxt = name_pos_r;
    name_flags_nxt = name_flags_r;
    rec_cnt_nxt = rec_cnt_r;
    rec_bytes_nxt = rec_bytes_r;
    name_beat = 1'b0;
    res = '0;
    res.header_ok = hdr_seen_r;

    unique case (phase_r)
      PH_HEADER: begin
        if (in_tdata == BYTE_FF) begin
          hdr_cnt_nxt = hdr_inc;
          if (hdr_inc >= HDR_DONE_COUNT) begin
            hdr_seen_nxt = 1'b1;
            res.header_ok = 1'b1;
            phase_nxt = PH_NAME;
            name_pos_nxt = '0;
            name_flags_nxt = '1;
          end
          if (in_tlast) begin
            res.status_valid = 1'b1;
            res.status_code = ST_UNKNOWN_NAME;
          end
        end else begin
          hdr_seen_nxt = 1'b0;
          res.header_ok = 1'b0;
          phase_nxt = PH_NAME;
          name_beat = 1'b1;
        end
      end
      PH_NAME: begin
        name_beat = 1'b1;
      end
      PH_SKIP: begin
        if (in_tdata == BYTE_BSLASH && !in_tlast) begin
          phase_nxt = PH_RECORD;
          rec_cnt_nxt = '0;
          rec_bytes_nxt = '0;
        end else if (in_tlast) begin
          res.status_valid = 1'b1;
          res.status_code = ST_NO_BACKSLASH;
        end
      end
      PH_RECORD: begin
        if (rec_cnt_r < REC_FULL_COUNT) begin
          rec_bytes_nxt = rec_shift;
          rec_cnt_nxt = rec_inc;
          if (rec_inc == REC_EOT_COUNT && rec_shift == REC_EOT) begin
            res.status_valid = 1'b1;
            res.status_code = ST_EOT;
            phase_nxt = PH_DONE;
          end else if (in_tlast) begin
            res.status_valid = 1'b1;
            res.status_code = ST_SHORT_RECORD;
          end
        end else begin
          // Separator beat: the record goes out whatever the byte is.
          res.record_valid = 1'b1;
          res.server_ip = rec_bytes_r[REC_W-1:PORT_W];
          res.server_port = rec_bytes_r[PORT_W-1:0];
          if (in_tdata != BYTE_BSLASH) begin
            res.status_valid = 1'b1;
            res.status_code = ST_BAD_SEP;
            phase_nxt = PH_DONE;
          end else if (in_tlast) begin
            res.status_valid = 1'b1;
            res.status_code = ST_AFTER_RECORD;
          end else begin
            rec_cnt_nxt = '0;
            rec_bytes_nxt = '0;
          end
        end
      end
      default: begin
        // Done: drop bytes until the end of the datagram.
      end
    endcase

    if (name_beat) begin
      name_flags_nxt = nm.flags;
      name_pos_nxt = nm.pos;
      if (nm.delim || in_tlast) begin
        priority if (nm.hit_list) begin
          if (in_tlast) begin
            res.status_valid = 1'b1;
            res.status_code = ST_NO_BACKSLASH;
          end else if (in_tdata == BYTE_BSLASH) begin
            phase_nxt = PH_RECORD;
            rec_cnt_nxt = '0;
            rec_bytes_nxt = '0;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end else if (nm.hit_other) begin
          res.status_valid = 1'b1;
          res.status_code = ST_UNDECODED;
          phase_nxt = PH_DONE;
        end else begin
          res.status_valid = 1'b1;
          res.status_code = ST_UNKNOWN_NAME;
          phase_nxt = PH_DONE;
        end
      end
    end

    // Rearm for the next datagram.
    if (in_tlast) begin
      phase_nxt = PH_HEADER;
      hdr_cnt_nxt = '0;
      hdr_seen_nxt = 1'b0;
      name_pos_nxt = '0;
      name_flags_nxt = '1;
      rec_cnt_nxt = '0;
      rec_bytes_nxt = '0;
    end
  end

  // Hold parser state between accepted beats.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hdr_cnt_r <= '0;
      hdr_seen_r <= 1'b0;
      name_pos_r <= '0;
      name_flags_r <= '1;
      rec_cnt_r <= '0;
      rec_bytes_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      hdr_seen_r <= hdr_seen_nxt;
      name_pos_r <= name_pos_nxt;
      name_flags_r <= name_flags_nxt;
      rec_cnt_r <= rec_cnt_nxt;
      rec_bytes_r <= rec_bytes_nxt;
    end
  end

  slrp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept && (res.record_valid || res.status_valid)),
    .res        (res),
    .free       (out_free),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

### src/slrp_checker.sv
`default_nettype none

module slrp_checker import slrp_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [OUT_TUSER_W-1:0] out_tuser
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Every result beat carries a record, a status or both.
  a_out_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[0] || out_tuser[1])
    else $error("result beat with neither record nor status");

  a_rec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[47:0] == 48'h0)
    else $error("address or port set without a record");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[1] ? out_tdata[50:48] != 3'd7 : out_tdata[50:48] == 3'd0))
    else $error("status code out of range");

  // Reset leaves nothing to deliver.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("result pending after reset");

endmodule

bind server_list_response_parser slrp_checker u_slrp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

### test/server_list_response_parser_tb.sv
`default_nettype none

// Self-checking bench for the server-list response parser. Whole datagrams go
// in one byte per beat; a shadow parser kept in this module works out which
// record and status beats each accepted byte must produce, and a monitor on
// the out_ channel compares every result beat, field by field, with the oldest
// beat still due.
module server_list_response_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slrp_pkg::*;

  typedef byte unsigned byte_q_t [$];

  // One directed datagram. In text, "$hh" stands for the byte 0xhh. Rows marked
  // typed carry their single result beat (a status, maybe with an all-zero
  // record); the other rows go through the shadow parser.
  typedef struct {
    string   text;
    bit      typed;
    bit      with_rec;
    status_t code;
    bit      hok;
  } dir_row_t;

  localparam int NUM_DIR = 18;
  localparam int RAND_BYTES = 350;

  dir_row_t dir_rows [NUM_DIR] = '{
    // Header alone: the fourth 0xFF is the final byte.
    '{"$ff$ff$ff$ff", 1'b1, 1'b0, ST_UNKNOWN_NAME, 1'b1},
    '{"$ff", 1'b1, 1'b0, ST_UNKNOWN_NAME, 1'b0},
    // Empty name: delimiter right at the start.
    '{" ", 1'b1, 1'b0, ST_UNKNOWN_NAME, 1'b0},
    // Fifth 0xFF already belongs to the name.
    '{"$ff$ff$ff$ff$ffx", 1'b1, 1'b0, ST_UNKNOWN_NAME, 1'b1},
    // Broken header: a valid name after two 0xFF bytes still cannot match.
    '{"$ff$ffinfoResponse\\", 1'b1, 1'b0, ST_UNKNOWN_NAME, 1'b0},
    // Status response; the trailing byte must be dropped.
    '{"statusResponse\\x", 1'b1, 1'b0, ST_UNDECODED, 1'b0},
    // Name cut by the end of the datagram.
    '{"$ff$ff$ff$ffinfoResponse", 1'b1, 1'b0, ST_UNDECODED, 1'b1},
    '{"getserversResponse", 1'b1, 1'b0, ST_NO_BACKSLASH, 1'b0},
    '{"getserversResponse xyz", 1'b1, 1'b0, ST_NO_BACKSLASH, 1'b0},
    // First backslash is the final byte.
    '{"getserversResponse \\", 1'b1, 1'b0, ST_NO_BACKSLASH, 1'b0},
    '{"getserversResponsX\\", 1'b1, 1'b0, ST_UNKNOWN_NAME, 1'b0},
    // Long name, position counter saturates.
    '{"getserversResponseXXXXXXXXXXXXXXXXXXXX\\", 1'b1, 1'b0, ST_UNKNOWN_NAME, 1'b0},
    '{"getserversResponse\\EOT", 1'b1, 1'b0, ST_EOT, 1'b0},
    '{"getserversResponse\\$01$02$03", 1'b1, 1'b0, ST_SHORT_RECORD, 1'b0},
    '{"getserversResponse\\$00$00$00$00$00$00\\", 1'b1, 1'b1, ST_AFTER_RECORD, 1'b0},
    // All-ones record, then a record closed by a wrong separator.
    '{"$ff$ff$ff$ffgetserversResponse$0a$7f\\$ff$ff$ff$ff$ff$ff\\$80$00$00$01$12$34/tail",
      1'b0, 1'b0, ST_EOT, 1'b0},
    '{"getserversResponse\\$0a$0b$0c$0d$0e$0f\\EOT\\junk", 1'b0, 1'b0, ST_EOT, 1'b0},
    '{"getserversResponse\\$c0$a8$00$01$6d$38\\$01$02$03$04$05$06\\",
      1'b0, 1'b0, ST_EOT, 1'b0}
  };

  string name_tab [NAME_CNT] = '{"getserversResponse", "statusResponse", "infoResponse"};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata = '0;      // [7:0] data_byte
  logic                   in_tlast = 1'b0;    // last_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;          // [31:0] ip, [47:32] port, [50:48] code
  logic [OUT_TUSER_W-1:0] out_tuser;          // [0] record_valid, [1] status_valid, [2] header_ok

  // Shadow parser state.
  phase_t      ph;
  logic [2:0]  ff_run;
  logic        hdr_seen;
  logic [4:0]  name_pos;
  logic [2:0]  name_live;
  logic [2:0]  rec_fill;
  logic [47:0] rec_shift;

  result_t due_beats [$];
  bit      use_shadow = 1'b1;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      err_count = 0;
  int      n_bytes = 0;
  int      n_dgrams = 0;
  int      n_records = 0;
  int      n_status = 0;

  always #6 clk = ~clk;

  server_list_response_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  function automatic void parse_clear();
    ph = PH_HEADER;
    ff_run = '0;
    hdr_seen = 1'b0;
    name_pos = '0;
    name_live = 3'b111;
    rec_fill = '0;
    rec_shift = '0;
  endfunction

  // Advance the shadow parser by one byte; return 1 when the byte yields a beat.
  function automatic bit parse_byte(input byte unsigned b, input bit last,
                                    output result_t r);
    logic       hok;
    bit         name_byte;
    bit         delim;
    logic [2:0] hit;
    r = '0;
    hok = hdr_seen;
    name_byte = 1'b0;
    case (ph)
      PH_HEADER: begin
        if (b == BYTE_FF) begin
          ff_run = ff_run + 3'd1;
          if (ff_run >= HDR_DONE_COUNT) begin
            hdr_seen = 1'b1;
            hok = 1'b1;
            ph = PH_NAME;
            name_pos = '0;
            name_live = 3'b111;
          end
          if (last) begin
            r.status_valid = 1'b1;
            r.status_code = ST_UNKNOWN_NAME;
          end
        end else begin
          // Partial header: any 0xFF already seen spoils every name.
          hdr_seen = 1'b0;
          hok = 1'b0;
          ph = PH_NAME;
          name_live = (ff_run != 3'd0) ? 3'b000 : 3'b111;
          name_pos = {2'b00, ff_run};
          name_byte = 1'b1;
        end
      end
      PH_NAME: name_byte = 1'b1;
      PH_SKIP: begin
        if (b == BYTE_BSLASH && !last) begin
          ph = PH_RECORD;
          rec_fill = '0;
          rec_shift = '0;
        end else if (last) begin
          r.status_valid = 1'b1;
          r.status_code = ST_NO_BACKSLASH;
        end
      end
      PH_RECORD: begin
        if (rec_fill < REC_FULL_COUNT) begin
          rec_shift = {rec_shift[39:0], b};
          rec_fill = rec_fill + 3'd1;
          if (rec_fill == REC_EOT_COUNT && rec_shift == REC_EOT) begin
            r.status_valid = 1'b1;
            r.status_code = ST_EOT;
            ph = PH_DONE;
          end else if (last) begin
            r.status_valid = 1'b1;
            r.status_code = ST_SHORT_RECORD;
          end
        end else begin
          // Separator byte: the record goes out whatever the byte is.
          r.record_valid = 1'b1;
          r.server_ip = rec_shift[47:16];
          r.server_port = rec_shift[15:0];
          if (b != BYTE_BSLASH) begin
            r.status_valid = 1'b1;
            r.status_code = ST_BAD_SEP;
            ph = PH_DONE;
          end else if (last) begin
            r.status_valid = 1'b1;
            r.status_code = ST_AFTER_RECORD;
          end else begin
            rec_fill = '0;
            rec_shift = '0;
          end
        end
      end
      default: ;
    endcase

    if (name_byte) begin
      delim = (b == BYTE_BSLASH) || (b == BYTE_SPACE) || (b == BYTE_NEWLINE);
      if (!delim) begin
        for (int k = 0; k < NAME_CNT; k++) begin
          if (name_pos >= name_tab[k].len() || name_tab[k][name_pos] != b)
            name_live[k] = 1'b0;
        end
        if (name_pos < NAME_POS_MAX) name_pos = name_pos + 5'd1;
      end
      if (delim || last) begin
        for (int k = 0; k < NAME_CNT; k++)
          hit[k] = name_live[k] && (name_pos == name_tab[k].len());
        if (hit[NAME_LIST]) begin
          if (last) begin
            r.status_valid = 1'b1;
            r.status_code = ST_NO_BACKSLASH;
          end else if (b == BYTE_BSLASH) begin
            ph = PH_RECORD;
            rec_fill = '0;
            rec_shift = '0;
          end else begin
            ph = PH_SKIP;
          end
        end else if (hit[NAME_STATUS] || hit[NAME_INFO]) begin
          r.status_valid = 1'b1;
          r.status_code = ST_UNDECODED;
          ph = PH_DONE;
        end else begin
          r.status_valid = 1'b1;
          r.status_code = ST_UNKNOWN_NAME;
          ph = PH_DONE;
        end
      end
    end

    if (last) parse_clear();
    r.header_ok = hok;
    return r.record_valid || r.status_valid;
  endfunction

  // Decode a directed row's text into bytes.
  function automatic byte_q_t text_bytes(input string s);
    byte_q_t q;
    int      i;
    q = {};
    i = 0;
    while (i < s.len()) begin
      if (s[i] == "$") begin
        q.push_back(8'(s.substr(i + 1, i + 2).atohex()));
        i += 3;
      end else begin
        q.push_back(s[i]);
        i++;
      end
    end
    return q;
  endfunction

  function automatic byte unsigned any_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic byte unsigned not_bslash();
    byte unsigned b;
    do b = any_byte(); while (b == BYTE_BSLASH);
    return b;
  endfunction

  // Random datagram: mostly well-formed server lists with random records and
  // a random ending; the rest is status/info, mangled names and noise.
  function automatic byte_q_t make_datagram();
    byte_q_t q;
    string   nm;
    int      kind;
    int      pick;
    q = {};
    kind = $urandom_range(99);
    pick = $urandom_range(9);
    if (pick < 8) repeat (4) q.push_back(BYTE_FF);
    else if (pick == 8) repeat ($urandom_range(1, 6)) q.push_back(BYTE_FF);

    if (kind >= 90) begin
      repeat ($urandom_range(1, 12)) q.push_back(any_byte());
      return q;
    end

    if (kind < 70 || kind >= 82) nm = "getserversResponse";
    else if (kind < 76) nm = "statusResponse";
    else nm = "infoResponse";
    if (kind >= 82) nm[$urandom_range(nm.len() - 1)] = 8'($urandom_range(32, 126));
    for (int k = 0; k < nm.len(); k++) q.push_back(nm[k]);

    if (kind >= 70 && kind < 82) begin
      pick = $urandom_range(3);
      if (pick == 1) q.push_back(BYTE_BSLASH);
      else if (pick == 2) q.push_back(BYTE_SPACE);
      else if (pick == 3) q.push_back(BYTE_NEWLINE);
      repeat ($urandom_range(4)) q.push_back(any_byte());
      return q;
    end

    // Optional filler before the first backslash.
    pick = $urandom_range(3);
    if (pick != 0) begin
      q.push_back(pick == 1 ? BYTE_SPACE : BYTE_NEWLINE);
      repeat ($urandom_range(3)) q.push_back(not_bslash());
    end
    if ($urandom_range(19) != 0) q.push_back(BYTE_BSLASH);
    repeat ($urandom_range(4)) begin
      repeat (6) q.push_back(any_byte());
      q.push_back(BYTE_BSLASH);
    end
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        q.push_back("E");
        q.push_back("O");
        q.push_back("T");
        repeat ($urandom_range(3)) q.push_back(any_byte());
      end
      4, 5: ;
      6: repeat ($urandom_range(1, 5)) q.push_back(any_byte());
      7: begin
        repeat (6) q.push_back(any_byte());
        q.push_back(not_bslash());
        repeat ($urandom_range(3)) q.push_back(any_byte());
      end
      8: repeat (6) q.push_back(any_byte());
      default: repeat ($urandom_range(1, 8)) q.push_back(any_byte());
    endcase
    return q;
  endfunction

  // Drive one datagram, one byte per beat, with random gaps before each beat.
  // Predict each byte's beat at the edge that accepts it.
  task automatic send_datagram(input byte_q_t dg);
    result_t r;
    bit      last;
    for (int i = 0; i < dg.size(); i++) begin
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      last = (i == dg.size() - 1);
      in_tvalid <= 1'b1;
      in_tdata <= dg[i];
      in_tlast <= last;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      n_bytes++;
      if (parse_byte(dg[i], last, r) && use_shadow) due_beats.push_back(r);
    end
    n_dgrams++;
  endtask

  function automatic void check_field(input string fname, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      err_count++;
    end
  endfunction

  // Receiver: stall at random according to the current phase.
  always @(posedge clk)
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

  // Result monitor: compare every accepted beat with the oldest one due.
  always @(posedge clk) begin
    result_t want;
    if (out_tvalid && out_tready) begin
      if (due_beats.size() == 0) begin
        $error("result beat with nothing due: tdata 0x%0h tuser 0x%0h", out_tdata, out_tuser);
        err_count++;
      end else begin
        want = due_beats.pop_front();
        check_field("record_valid", want.record_valid, out_tuser[0]);
        check_field("server_ip", want.server_ip, out_tdata[IP_W-1:0]);
        check_field("server_port", want.server_port, out_tdata[IP_W +: PORT_W]);
        check_field("status_valid", want.status_valid, out_tuser[1]);
        check_field("status_code", want.status_code, out_tdata[REC_W +: CODE_W]);
        check_field("header_ok", want.header_ok, out_tuser[2]);
      end
      if (out_tuser[0] === 1'b1) n_records++;
      if (out_tuser[1] === 1'b1) n_status++;
    end
  end

  initial begin
    byte_q_t dg;
    result_t want;
    int      rand_bytes;
    rand_bytes = 0;
    parse_clear();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed datagrams, no idling. Typed rows queue their beat up front.
    for (int i = 0; i < NUM_DIR; i++) begin
      dg = text_bytes(dir_rows[i].text);
      use_shadow = !dir_rows[i].typed;
      if (dir_rows[i].typed) begin
        want = '0;
        want.record_valid = dir_rows[i].with_rec;
        want.status_valid = 1'b1;
        want.status_code = dir_rows[i].code;
        want.header_ok = dir_rows[i].hok;
        due_beats.push_back(want);
      end
      send_datagram(dg);
    end
    use_shadow = 1'b1;

    // Random datagrams in four idling phases: none, sender, receiver, both.
    while (rand_bytes < RAND_BYTES) begin
      case (rand_bytes * 4 / RAND_BYTES)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      dg = make_datagram();
      send_datagram(dg);
      rand_bytes += dg.size();
    end
    in_tvalid <= 1'b0;

    // Drain what is still due, then wait for stray beats.
    while (due_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d datagrams (%0d bytes): headers, names, skips, records, EOT and errors",
             n_dgrams, n_bytes);
    $display("Checked %0d record beats and %0d status beats, %0d field errors",
             n_records, n_status, err_count);
    if (err_count == 0 && due_beats.size() == 0)
      $display("server_list_response_parser: match");
    else
      $display("server_list_response_parser: mismatch");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("server_list_response_parser: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
src/slrp_pkg.sv
src/slrp_name_match.sv
src/slrp_out_reg.sv
src/server_list_response_parser.sv
src/slrp_checker.sv
test/server_list_response_parser_tb.sv
